@@ hdl/fvn_pkg.sv @@
// shared widths, constants and types for the fractal value noise shader
package fvn_pkg;

    localparam int OCTAVES   = 4;
    localparam int TAB_DEPTH = 256;
    localparam int TAB_AW    = 8;
    localparam int TAB_W     = 8;
    localparam int COORD_W   = 10;
    localparam int FREQ_W    = 24;
    localparam int SEED_W    = 8;
    localparam int FRAC_W    = 16;
    localparam int FADE_W    = 17;
    localparam int POLY_W    = 20;
    localparam int OCT_W     = 24;
    localparam int LEVEL_W   = 16;
    localparam int SHADE_W   = 8;
    localparam int PROD_W    = COORD_W + FREQ_W;
    localparam int SX_W      = PROD_W + OCTAVES;
    localparam int SUM_W     = OCT_W + OCTAVES;
    localparam int DIVIN_W   = SUM_W - 8;
    localparam int DIV_K     = DIVIN_W + 1;
    localparam int NORM_DIV  = (1 << OCTAVES) - 1;
    localparam int DIV_M     = (1 << DIV_K) / NORM_DIV;
    localparam int OCT_LAT   = 5;
    localparam int POST_LAT  = 5;
    localparam int PIPE_DEPTH = 2 + OCT_LAT + POST_LAT;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 24;

    localparam logic [COORD_W-1:0] COORD_MAX  = 10'd1023;
    localparam logic [FREQ_W-1:0]  FREQ_RESET = 24'd251658;
    localparam logic [FREQ_W-1:0]  BAND_LOW   = 24'd167773;
    localparam logic [FREQ_W-1:0]  BAND_HIGH  = 24'd335544;
    localparam logic [FADE_W-1:0]  FADE_ONE   = 17'h10000;
    localparam logic [POLY_W:0]    POLY_BASE  = 21'd655360;

    localparam logic [LEVEL_W-1:0] LVL_T1 = 16'd13107;
    localparam logic [LEVEL_W-1:0] LVL_T2 = 16'd26214;
    localparam logic [LEVEL_W-1:0] LVL_T3 = 16'd39321;
    localparam logic [SHADE_W-1:0] SHADE_OFF = 8'd0;
    localparam logic [SHADE_W-1:0] SHADE_1   = 8'd100;
    localparam logic [SHADE_W-1:0] SHADE_2   = 8'd150;
    localparam logic [SHADE_W-1:0] SHADE_3   = 8'd200;
    localparam logic [SHADE_W-1:0] SHADE_4   = 8'd250;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic CFG_FREQUENCY = 1'b0;
    localparam logic CFG_SEED      = 1'b1;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [TAB_AW-1:0] addr;
        logic [TAB_W-1:0]  data;
    } tab_ctl_t;

endpackage

@@ hdl/fvn_ram.sv @@
// generic ram, one write port and two registered read ports
module fvn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old word on a same-cycle write
    always_ff @(posedge aclk) begin
        if (en) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
        if (we) begin
            mem[waddr] <= wdata;
        end
    end
endmodule

@@ hdl/fvn_octave.sv @@
// one octave: corner hashes, quintic fade and bilinear blend over five stages
module fvn_octave (
    input  logic                            aclk,
    input  fvn_pkg::tab_ctl_t               tab,
    input  logic [fvn_pkg::SEED_W-1:0]      seed,
    input  logic [fvn_pkg::TAB_AW-1:0]      x_int,
    input  logic [fvn_pkg::TAB_AW-1:0]      y_int,
    input  logic [fvn_pkg::FRAC_W-1:0]      x_frac,
    input  logic [fvn_pkg::FRAC_W-1:0]      y_frac,
    output logic [fvn_pkg::OCT_W-1:0]       oct_val
);
    localparam int AW = fvn_pkg::TAB_AW;
    localparam int TW = fvn_pkg::TAB_W;
    localparam int FW = fvn_pkg::FRAC_W;
    localparam int DW = fvn_pkg::FADE_W;
    localparam int PW = fvn_pkg::POLY_W;
    localparam int OW = fvn_pkg::OCT_W;

    // stage a
    logic [TW-1:0] hy_a, hy_b;
    logic [AW-1:0] xi_a_reg;
    logic [FW-1:0] tx_a_reg, ty_a_reg, t2x_a_reg, t2y_a_reg;
    logic [FW-1:0] t2x_a_next, t2y_a_next;
    logic [2*FW-1:0] sqx, sqy;
    // stage b
    logic [TW-1:0] c_s, c_t, c_u, c_v;
    logic [FW-1:0] t3x_b_reg, t3y_b_reg, t3x_b_next, t3y_b_next;
    logic [PW-1:0] px_b_reg, py_b_reg;
    logic [PW:0]   px_full, py_full;
    logic [2*FW-1:0] cbx, cby;
    // stage c
    logic [TW-1:0] s_c_reg, t_c_reg, u_c_reg, v_c_reg;
    logic [DW-1:0] fx_c_reg, fy_c_reg;
    logic [FW+PW-1:0] fpx, fpy;
    // stage d
    logic [OW-1:0] low_d_reg, high_d_reg, low_d_next, high_d_next;
    logic [DW-1:0] fy_d_reg;
    logic [OW:0]   low_full, high_full;
    // stage e
    logic [OW-1:0] oct_e_reg;
    logic [OW+DW-1:0] mix_full;
    logic [AW-1:0] y0_addr, y1_addr, a0_addr, a1_addr, b0_addr, b1_addr;

    assign y0_addr = y_int + AW'(seed);
    assign y1_addr = y_int + AW'(seed) + AW'(1);

    fvn_ram #(.WIDTH(TW), .DEPTH(fvn_pkg::TAB_DEPTH)) u_ram_row (
        .aclk(aclk), .en(tab.en), .we(tab.we), .waddr(tab.addr), .wdata(tab.data),
        .raddr_a(y0_addr), .raddr_b(y1_addr), .rdata_a(hy_a), .rdata_b(hy_b)
    );

    assign sqx = (2*FW)'(x_frac) * (2*FW)'(x_frac);
    assign sqy = (2*FW)'(y_frac) * (2*FW)'(y_frac);
    assign t2x_a_next = sqx[2*FW-1:FW];
    assign t2y_a_next = sqy[2*FW-1:FW];

    assign a0_addr = hy_a + xi_a_reg;
    assign a1_addr = hy_a + xi_a_reg + AW'(1);
    assign b0_addr = hy_b + xi_a_reg;
    assign b1_addr = hy_b + xi_a_reg + AW'(1);

    fvn_ram #(.WIDTH(TW), .DEPTH(fvn_pkg::TAB_DEPTH)) u_ram_lo (
        .aclk(aclk), .en(tab.en), .we(tab.we), .waddr(tab.addr), .wdata(tab.data),
        .raddr_a(a0_addr), .raddr_b(a1_addr), .rdata_a(c_s), .rdata_b(c_t)
    );

    fvn_ram #(.WIDTH(TW), .DEPTH(fvn_pkg::TAB_DEPTH)) u_ram_hi (
        .aclk(aclk), .en(tab.en), .we(tab.we), .waddr(tab.addr), .wdata(tab.data),
        .raddr_a(b0_addr), .raddr_b(b1_addr), .rdata_a(c_u), .rdata_b(c_v)
    );

    // fade polynomial 10 - 15t + 6t^2, stays positive over the unit range
    assign cbx = (2*FW)'(t2x_a_reg) * (2*FW)'(tx_a_reg);
    assign cby = (2*FW)'(t2y_a_reg) * (2*FW)'(ty_a_reg);
    assign t3x_b_next = cbx[2*FW-1:FW];
    assign t3y_b_next = cby[2*FW-1:FW];
    assign px_full = fvn_pkg::POLY_BASE + (PW+1)'(t2x_a_reg) * (PW+1)'(6)
                     - (PW+1)'(tx_a_reg) * (PW+1)'(15);
    assign py_full = fvn_pkg::POLY_BASE + (PW+1)'(t2y_a_reg) * (PW+1)'(6)
                     - (PW+1)'(ty_a_reg) * (PW+1)'(15);

    assign fpx = (FW+PW)'(t3x_b_reg) * (FW+PW)'(px_b_reg);
    assign fpy = (FW+PW)'(t3y_b_reg) * (FW+PW)'(py_b_reg);

    assign low_full  = (OW+1)'(s_c_reg) * (OW+1)'(fvn_pkg::FADE_ONE - fx_c_reg)
                     + (OW+1)'(t_c_reg) * (OW+1)'(fx_c_reg);
    assign high_full = (OW+1)'(u_c_reg) * (OW+1)'(fvn_pkg::FADE_ONE - fx_c_reg)
                     + (OW+1)'(v_c_reg) * (OW+1)'(fx_c_reg);
    assign low_d_next  = low_full[OW-1:0];
    assign high_d_next = high_full[OW-1:0];

    assign mix_full = (OW+DW)'(low_d_reg) * (OW+DW)'(fvn_pkg::FADE_ONE - fy_d_reg)
                    + (OW+DW)'(high_d_reg) * (OW+DW)'(fy_d_reg);

    always_ff @(posedge aclk) begin
        if (tab.en) begin
            xi_a_reg  <= x_int;
            tx_a_reg  <= x_frac;
            ty_a_reg  <= y_frac;
            t2x_a_reg <= t2x_a_next;
            t2y_a_reg <= t2y_a_next;

            t3x_b_reg <= t3x_b_next;
            t3y_b_reg <= t3y_b_next;
            px_b_reg  <= px_full[PW-1:0];
            py_b_reg  <= py_full[PW-1:0];

            s_c_reg  <= c_s;
            t_c_reg  <= c_t;
            u_c_reg  <= c_u;
            v_c_reg  <= c_v;
            fx_c_reg <= fpx[FW+DW-1:FW];
            fy_c_reg <= fpy[FW+DW-1:FW];

            low_d_reg  <= low_d_next;
            high_d_reg <= high_d_next;
            fy_d_reg   <= fy_c_reg;

            oct_e_reg <= mix_full[OW+FW-1:FW];
        end
    end

    assign oct_val = oct_e_reg;
endmodule

@@ hdl/fvn_post.sv @@
// octave sum, normalisation by constant reciprocal and fourth-power contrast
module fvn_post (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [fvn_pkg::OCT_W-1:0]     oct_val [fvn_pkg::OCTAVES],
    output logic [fvn_pkg::LEVEL_W-1:0]   level
);
    localparam int SW = fvn_pkg::SUM_W;
    localparam int AW = fvn_pkg::DIVIN_W;
    localparam int K  = fvn_pkg::DIV_K;
    localparam int MW = AW + K + 1;
    localparam int LW = fvn_pkg::LEVEL_W;

    logic [SW-1:0] sum_reg, sum_next;
    logic [AW-1:0] a_q_reg, q0_reg, rem, quo;
    logic [MW-1:0] recip;
    logic [LW-1:0] h_reg, h_next, h2_reg, lvl_reg;
    logic [2*LW-1:0] hh, h4;

    always_comb begin
        sum_next = '0;
        for (int i = 0; i < fvn_pkg::OCTAVES; i++) begin
            sum_next = sum_next + (SW'(oct_val[i]) << (fvn_pkg::OCTAVES - 1 - i));
        end
    end

    // estimate can fall one short, fixed by a single compare
    assign recip = MW'(sum_reg[SW-1:8]) * MW'(fvn_pkg::DIV_M);
    assign rem   = a_q_reg - AW'(q0_reg * AW'(fvn_pkg::NORM_DIV));
    assign quo   = (rem >= AW'(fvn_pkg::NORM_DIV)) ? q0_reg + AW'(1) : q0_reg;
    assign h_next = {1'b1, quo[LW-1:1]};

    assign hh = (2*LW)'(h_reg) * (2*LW)'(h_reg);
    assign h4 = (2*LW)'(h2_reg) * (2*LW)'(h2_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= sum_next;
            a_q_reg <= sum_reg[SW-1:8];
            q0_reg  <= recip[K+AW-1:K];
            h_reg   <= h_next;
            h2_reg  <= hh[2*LW-1:LW];
            lvl_reg <= h4[2*LW-1:LW];
        end
    end

    assign level = lvl_reg;
endmodule

@@ hdl/fractal_value_noise_shader.sv @@
// top level: input stage, coordinate scaling, octave lanes, post stage and output register
//
//  channel  direction  handshake               payload
//  s_       in         s_tvalid / s_tready     tuser: opcode; tdata: table_index, table_value,
//                                              col, row
//  m_       out        m_tvalid / m_tready     tdata: noise_level, shade
//  cfg_     in         cfg_we                  cfg_addr, cfg_wdata
//
//  one item per cycle while the output register is not held; an evaluate result passes through
//  the input stage, scaling multiply, five octave stages, five post stages and output register
//  a load item writes every table copy from its second input register and gives no result
//  the whole pipeline holds while the output register is full and not taken
//  aresetn clears valid bits and seed, loads freq with FREQ_RESET; the table is not cleared
module fractal_value_noise_shader (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fvn_pkg::S_DATA_W-1:0]      s_tdata,  // table_index, table_value, col, row
    input  logic [0:0]                        s_tuser,  // opcode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fvn_pkg::M_DATA_W-1:0]      m_tdata,  // noise_level, shade
    input  logic                              cfg_we,
    input  logic                              cfg_addr,
    input  logic [fvn_pkg::FREQ_W-1:0]        cfg_wdata
);
    localparam int PD = fvn_pkg::PIPE_DEPTH;
    localparam int CW = fvn_pkg::COORD_W;
    localparam int PW = fvn_pkg::PROD_W;
    localparam int XW = fvn_pkg::SX_W;

    logic adv;
    logic [PD-1:0] vld_reg, op_reg;
    logic [fvn_pkg::FREQ_W-1:0] freq_reg;
    logic [fvn_pkg::SEED_W-1:0] seed_reg;

    logic [fvn_pkg::TAB_AW-1:0] idx0_reg, idx1_reg;
    logic [fvn_pkg::TAB_W-1:0]  val0_reg, val1_reg;
    logic [CW-1:0] cx0_reg, cy0_reg, cx_next, cy_next;
    logic [PW-1:0] px1_reg, py1_reg;

    fvn_pkg::tab_ctl_t tab;
    logic [fvn_pkg::OCT_W-1:0] oct_val [fvn_pkg::OCTAVES];
    logic [fvn_pkg::LEVEL_W-1:0] level;
    logic [fvn_pkg::SHADE_W-1:0] shade;

    logic out_vld_reg;
    logic [fvn_pkg::LEVEL_W-1:0] out_lvl_reg;
    logic [fvn_pkg::SHADE_W-1:0] out_shade_reg;

    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_reg <= fvn_pkg::FREQ_RESET;
            seed_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                fvn_pkg::CFG_FREQUENCY: freq_reg <= cfg_wdata;
                fvn_pkg::CFG_SEED:      seed_reg <= cfg_wdata[fvn_pkg::SEED_W-1:0];
                default:                freq_reg <= freq_reg;
            endcase
        end
    end

    assign cx_next = (s_tdata[25:16] > fvn_pkg::COORD_MAX) ? fvn_pkg::COORD_MAX : s_tdata[25:16];
    assign cy_next = (s_tdata[35:26] > fvn_pkg::COORD_MAX) ? fvn_pkg::COORD_MAX : s_tdata[35:26];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            op_reg      <= '0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[PD-2:0], s_tvalid};
            op_reg      <= {op_reg[PD-2:0], s_tuser[0]};
            out_vld_reg <= vld_reg[PD-1] && (op_reg[PD-1] == fvn_pkg::OP_EVAL);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            idx0_reg <= s_tdata[7:0];
            val0_reg <= s_tdata[15:8];
            cx0_reg  <= cx_next;
            cy0_reg  <= cy_next;
            idx1_reg <= idx0_reg;
            val1_reg <= val0_reg;
            px1_reg  <= PW'(cx0_reg) * PW'(freq_reg);
            py1_reg  <= PW'(cy0_reg) * PW'(freq_reg);
            out_lvl_reg   <= level;
            out_shade_reg <= shade;
        end
    end

    assign tab.en   = adv;
    assign tab.we   = adv && vld_reg[1] && (op_reg[1] == fvn_pkg::OP_LOAD);
    assign tab.addr = idx1_reg;
    assign tab.data = val1_reg;

    // octave i scales by 2^i: integer cell and 16-bit fraction taken from the shifted product
    for (genvar i = 0; i < fvn_pkg::OCTAVES; i++) begin : g_oct
        logic [XW-1:0] sx, sy;
        assign sx = XW'(px1_reg) << i;
        assign sy = XW'(py1_reg) << i;

        fvn_octave u_oct (
            .aclk    (aclk),
            .tab     (tab),
            .seed    (seed_reg),
            .x_int   (sx[31:24]),
            .y_int   (sy[31:24]),
            .x_frac  (sx[23:8]),
            .y_frac  (sy[23:8]),
            .oct_val (oct_val[i])
        );
    end

    fvn_post u_post (
        .aclk    (aclk),
        .en      (adv),
        .oct_val (oct_val),
        .level   (level)
    );

    always_comb begin
        if (freq_reg < fvn_pkg::BAND_LOW || freq_reg > fvn_pkg::BAND_HIGH) begin
            shade = fvn_pkg::SHADE_OFF;
        end else begin
            priority if (level <= fvn_pkg::LVL_T1) shade = fvn_pkg::SHADE_1;
            else if (level <= fvn_pkg::LVL_T2)     shade = fvn_pkg::SHADE_2;
            else if (level <= fvn_pkg::LVL_T3)     shade = fvn_pkg::SHADE_3;
            else                                   shade = fvn_pkg::SHADE_4;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_shade_reg, out_lvl_reg};
endmodule

@@ sim/fractal_value_noise_shader_test.sv @@
// testbench for the fractal value noise shader: random streams checked against a local predictor
module fractal_value_noise_shader_test;
    timeunit 1ns;
    timeprecision 1ps;

    // expected noise results in arrival order, with the predictor that fills it
    class noise_scoreboard;
        logic [7:0]  perm [256];
        logic [23:0] freq;
        logic [7:0]  seed;
        logic [23:0] pending [$];
        int          errors;

        function void clear_regs();
            freq = fvn_pkg::FREQ_RESET;
            seed = 8'd0;
        endfunction

        function longint unsigned ease(longint unsigned t);
            longint unsigned t2, t3, poly;
            t2 = (t * t) >> 16;
            t3 = (t2 * t) >> 16;
            poly = 655360 + 6 * t2 - 15 * t;
            return (t3 * poly) >> 16;
        endfunction

        function longint unsigned corner(logic [7:0] x, logic [7:0] y);
            logic [7:0] first;
            first = perm[8'(y + seed)];
            return perm[8'(first + x)];
        endfunction

        function longint unsigned octave(longint unsigned cx, longint unsigned cy, int sh);
            longint unsigned sx, sy, fx, fy, lo, hi;
            logic [7:0] xi, yi;
            sx = (cx * freq) << sh;
            sy = (cy * freq) << sh;
            xi = 8'(sx >> 24);
            yi = 8'(sy >> 24);
            fx = ease((sx >> 8) & 64'hFFFF);
            fy = ease((sy >> 8) & 64'hFFFF);
            lo = corner(xi, yi) * (65536 - fx) + corner(xi + 8'd1, yi) * fx;
            hi = corner(xi, yi + 8'd1) * (65536 - fx) + corner(xi + 8'd1, yi + 8'd1) * fx;
            return (lo * (65536 - fy) + hi * fy) >> 16;
        endfunction

        function void note_input(logic op, logic [39:0] d);
            longint unsigned total, h, h2, lvl;
            logic [7:0] shade;
            if (op == fvn_pkg::OP_LOAD) begin
                perm[d[7:0]] = d[15:8];
                return;
            end
            total = 0;
            for (int i = 0; i < fvn_pkg::OCTAVES; i++)
                total += octave(d[25:16], d[35:26], i) << (fvn_pkg::OCTAVES - 1 - i);
            h = (total / (256 * fvn_pkg::NORM_DIV) + 65536) >> 1;
            h2 = (h * h) >> 16;
            lvl = (h2 * h2) >> 16;
            if (lvl > 65535) lvl = 65535;
            if (freq >= fvn_pkg::BAND_LOW && freq <= fvn_pkg::BAND_HIGH) begin
                if (lvl <= fvn_pkg::LVL_T1) shade = fvn_pkg::SHADE_1;
                else if (lvl <= fvn_pkg::LVL_T2) shade = fvn_pkg::SHADE_2;
                else if (lvl <= fvn_pkg::LVL_T3) shade = fvn_pkg::SHADE_3;
                else shade = fvn_pkg::SHADE_4;
            end else begin
                shade = fvn_pkg::SHADE_OFF;
            end
            pending.push_back({shade, 16'(lvl)});
        endfunction

        task report(string what);
            $display("error: %s at %0t", what, $time);
            errors++;
        endtask

        task check_result(logic [23:0] got);
            logic [23:0] want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            want = pending.pop_front();
            if (got[15:0] !== want[15:0])
                report($sformatf("noise_level %0d, wanted %0d", got[15:0], want[15:0]));
            if (got[23:16] !== want[23:16])
                report($sformatf("shade %0d, wanted %0d", got[23:16], want[23:16]));
        endtask
    endclass

    logic        aclk, aresetn;
    logic        s_tvalid, s_tready, m_tvalid, m_tready;
    logic [39:0] s_tdata;
    logic [0:0]  s_tuser;
    logic [23:0] m_tdata;
    logic        cfg_we, cfg_addr;
    logic [23:0] cfg_wdata;
    longint      cycles;
    noise_scoreboard board;

    fractal_value_noise_shader DUT (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int pause_len();
        if ($urandom_range(9) < 6) return 0;
        if ($urandom_range(19) != 0) return $urandom_range(3);
        return $urandom_range(30, 8);
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: random stalls when stall_mode is set, checks each transfer
    int stall_mode;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
        if (stall_mode == 0) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(9) < 7) || (pause_len() == 0);
    end

    task automatic send(logic op, logic [39:0] d);
        int g;
        g = pause_len();
        repeat (g) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_input(op, d);
    endtask

    task automatic idle_out();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (fvn_pkg::PIPE_DEPTH + 4) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [23:0] v);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == fvn_pkg::CFG_FREQUENCY) board.freq = v;
        else board.seed = v[7:0];
    endtask

    function automatic logic [39:0] point(logic [9:0] c, logic [9:0] r);
        return {4'd0, r, c, 16'd0};
    endfunction

    task automatic eval_burst(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(15) == 0)
                send(fvn_pkg::OP_EVAL, {$urandom} & 40'hFF_FFFF_FFFF);
            else if ($urandom_range(3) == 0)
                send(fvn_pkg::OP_LOAD, {24'd0, 8'($urandom), 8'($urandom)});
            else
                send(fvn_pkg::OP_EVAL, point($urandom_range(1023), $urandom_range(1023)));
        end
    endtask

    logic [23:0] freqs [6];

    initial begin
        board = new();
        board.clear_regs();
        board.errors = 0;
        cycles = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = fvn_pkg::OP_LOAD;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = fvn_pkg::CFG_FREQUENCY;
        cfg_wdata = '0;
        stall_mode = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill the whole table before any evaluation
        for (int i = 0; i < 256; i++)
            send(fvn_pkg::OP_LOAD, {24'd0, 8'(255 - i), 8'(i)});
        send(fvn_pkg::OP_LOAD, {24'd0, 8'hFF, 8'h00});
        send(fvn_pkg::OP_LOAD, {24'd0, 8'h00, 8'hFF});
        // directed corners and one inner point at the reset setting
        send(fvn_pkg::OP_EVAL, point(10'd0, 10'd0));
        send(fvn_pkg::OP_EVAL, point(10'd1023, 10'd1023));
        send(fvn_pkg::OP_EVAL, point(10'd1023, 10'd0));
        send(fvn_pkg::OP_EVAL, point(10'd0, 10'd1023));
        send(fvn_pkg::OP_EVAL, point(10'h2AA, 10'h155));
        send(fvn_pkg::OP_EVAL, 40'hFF_FFFF_FFFF);
        eval_burst(20);
        idle_out();

        freqs = '{24'd0, 24'hFFFFFF, fvn_pkg::BAND_LOW, fvn_pkg::BAND_HIGH,
                  fvn_pkg::BAND_LOW - 24'd1, fvn_pkg::BAND_HIGH + 24'd1};
        foreach (freqs[j]) begin
            write_reg(fvn_pkg::CFG_FREQUENCY, freqs[j]);
            write_reg(fvn_pkg::CFG_SEED, (j == 1) ? 24'hFFFFFF : 24'($urandom_range(255)));
            stall_mode = j % 2;
            eval_burst(16);
            idle_out();
        end
        write_reg(fvn_pkg::CFG_FREQUENCY, 24'($urandom));
        write_reg(fvn_pkg::CFG_SEED, 24'd0);
        stall_mode = 1;
        eval_burst(20);
        idle_out();

        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

@@ fractal_value_noise_shader.f @@
hdl/fvn_pkg.sv
hdl/fvn_ram.sv
hdl/fvn_octave.sv
hdl/fvn_post.sv
hdl/fractal_value_noise_shader.sv
sim/fractal_value_noise_shader_test.sv
